@@ rtl/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// Opcodes and shared types for the signed fixed-point alu.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int OP_WIDTH = 4;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MIN  = 4'd4,
    OP_MAX  = 4'd5,
    OP_INC  = 4'd6,
    OP_DEC  = 4'd7,
    OP_INTP = 4'd8
  } op_t;

  // what the front decided about an item
  typedef struct packed {
    logic is_add;
    logic is_sub;
    logic is_mul;
    logic is_div;
    logic is_min;
    logic is_max;
    logic is_inc;
    logic is_dec;
    logic is_intp;
    logic lt;
    logic eq;
    logic gt;
    logic neg;
  } cls_t;

endpackage

@@ rtl/fpa_front.sv @@
// ----------------------------------------------------------------------------
// fpa_front
// Decodes the opcode, compares operands and pushes the item into the queue.
// ----------------------------------------------------------------------------
module fpa_front #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_take,
  input  logic [fpa_pkg::OP_WIDTH-1:0] in_opcode,
  input  logic signed [WORD_WIDTH-1:0] in_operand_a,
  input  logic signed [WORD_WIDTH-1:0] in_operand_b,
  output logic                         q_valid,
  output fpa_pkg::cls_t                q_cls,
  output logic signed [WORD_WIDTH-1:0] q_a,
  output logic signed [WORD_WIDTH-1:0] q_b
);
  import fpa_pkg::*;

  logic                         valid_r;
  cls_t                         cls_r, cls_nxt;
  logic signed [WORD_WIDTH-1:0] a_r, b_r;

  always_comb begin
    cls_nxt = '0;
    unique case (in_opcode)
      OP_ADD:  cls_nxt.is_add  = 1'b1;
      OP_SUB:  cls_nxt.is_sub  = 1'b1;
      OP_MUL:  cls_nxt.is_mul  = 1'b1;
      OP_DIV:  cls_nxt.is_div  = 1'b1;
      OP_MIN:  cls_nxt.is_min  = 1'b1;
      OP_MAX:  cls_nxt.is_max  = 1'b1;
      OP_INC:  cls_nxt.is_inc  = 1'b1;
      OP_DEC:  cls_nxt.is_dec  = 1'b1;
      OP_INTP: cls_nxt.is_intp = 1'b1;
      default: ;
    endcase
    cls_nxt.lt  = in_operand_a < in_operand_b;
    cls_nxt.eq  = in_operand_a == in_operand_b;
    cls_nxt.gt  = in_operand_a > in_operand_b;
    cls_nxt.neg = in_operand_a[WORD_WIDTH-1] ^ in_operand_b[WORD_WIDTH-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_take;
    end
    if (in_take) begin
      cls_r <= cls_nxt;
      a_r   <= in_operand_a;
      b_r   <= in_operand_b;
    end
  end

  assign q_valid = valid_r;
  assign q_cls   = cls_r;
  assign q_a     = a_r;
  assign q_b     = b_r;
endmodule

@@ rtl/fpa_back.sv @@
// ----------------------------------------------------------------------------
// fpa_back
// Executes one item: simple ops, a staged multiply and a radix-2 divider.
// ----------------------------------------------------------------------------
module fpa_back #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  fpa_pkg::cls_t                q_cls,
  input  logic signed [WORD_WIDTH-1:0] q_a,
  input  logic signed [WORD_WIDTH-1:0] q_b,
  output logic                         q_pop,
  output logic                         out_valid,
  output logic signed [WORD_WIDTH-1:0] out_result,
  output logic                         out_a_less,
  output logic                         out_a_equal,
  output logic                         out_a_greater,
  output logic                         out_divide_by_zero,
  output logic                         out_overflow
);
  import fpa_pkg::*;

  localparam int W   = WORD_WIDTH;
  localparam int HW  = (W + 1) / 2;
  localparam int PW  = 2 * W;
  localparam int NW  = W + FRAC_BITS;
  localparam int CW  = $clog2(NW + 1);

  localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINNEG = {1'b1, {(W-1){1'b0}}};

  // busy while the divider or the multiplier occupies the unit
  logic          div_busy_r;
  logic [CW-1:0] div_cnt_r;
  logic [NW-1:0] div_num_r;
  logic [W:0]    div_rem_r;
  logic [NW-1:0] div_quo_r;
  logic [W-1:0]  div_d_r;
  logic [1:0]    mul_ph_r;
  logic [W-1:0]  ma_r, mb_r;
  logic [PW-1:0] prod_r;
  cls_t          cls_r;

  logic [W-1:0]  ma, mb;
  assign ma = q_a[W-1] ? (~q_a + 1'b1) : q_a;
  assign mb = q_b[W-1] ? (~q_b + 1'b1) : q_b;

  logic idle;
  assign idle  = !div_busy_r && (mul_ph_r == 2'd0);
  assign q_pop = q_valid && idle;

  // add, sub, inc, dec, min, max and integer part
  logic [W-1:0] fr;
  logic         fovf;
  logic [W-1:0] sa, sb, sr;
  logic         ssub;
  always_comb begin
    ssub = q_cls.is_sub || q_cls.is_dec;
    sa   = q_a;
    sb   = (q_cls.is_inc || q_cls.is_dec) ? W'(1) : q_b;
    sr   = ssub ? (sa - sb) : (sa + sb);
    fr   = '0;
    fovf = 1'b0;
    if (q_cls.is_add || q_cls.is_sub || q_cls.is_inc || q_cls.is_dec) begin
      if (ssub ? (sa[W-1] != sb[W-1] && sr[W-1] != sa[W-1])
               : (sa[W-1] == sb[W-1] && sr[W-1] != sa[W-1])) begin
        fovf = 1'b1;
        fr   = sa[W-1] ? MINNEG : MAXPOS;
      end else begin
        fr = sr;
      end
    end else if (q_cls.is_min) begin
      fr = q_cls.lt ? q_a : q_b;
    end else if (q_cls.is_max) begin
      fr = q_cls.gt ? q_a : q_b;
    end else if (q_cls.is_intp) begin
      fr = W'(q_a >>> FRAC_BITS);
    end
  end

  // four partial products of half-width operand pieces
  logic [HW-1:0] a0, a1, b0, b1;
  assign a0 = ma_r[HW-1:0];
  assign b0 = mb_r[HW-1:0];
  assign a1 = HW'(ma_r >> HW);
  assign b1 = HW'(mb_r >> HW);

  logic [PW-1:0] pp;
  always_comb begin
    unique case (mul_ph_r)
      2'd1:    pp = PW'(a0 * b0) + (PW'(a0 * b1) << HW);
      2'd2:    pp = (PW'(a1 * b0) << HW) + (PW'(a1 * b1) << (2 * HW));
      default: pp = '0;
    endcase
  end

  // divider step
  logic [W:0] trial;
  logic [W:0] shifted;
  assign shifted = {div_rem_r[W-1:0], div_num_r[NW-1]};
  assign trial   = shifted - {1'b0, div_d_r};

  // sign and saturate a wide magnitude
  function automatic logic [W:0] sign_sat(input logic neg, input logic [PW-1:0] mag);
    logic [PW-1:0] lim;
    logic [W-1:0]  lo;
    lim = neg ? PW'(MINNEG) : PW'(MAXPOS);
    lo  = mag[W-1:0];
    if (mag > lim) sign_sat = {1'b1, neg ? MINNEG : MAXPOS};
    else           sign_sat = {1'b0, neg ? (~lo + 1'b1) : lo};
  endfunction

  logic [W:0] mres, dres;
  assign mres = sign_sat(cls_r.neg, PW'(prod_r >> FRAC_BITS));
  assign dres = sign_sat(cls_r.neg, PW'(div_quo_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      mul_ph_r   <= 2'd0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (q_pop) begin
        cls_r <= q_cls;
        if (q_cls.is_mul) begin
          mul_ph_r <= 2'd1;
          ma_r     <= ma;
          mb_r     <= mb;
          prod_r   <= '0;
        end else if (q_cls.is_div && q_b != '0) begin
          div_busy_r <= 1'b1;
          div_cnt_r  <= CW'(NW);
          div_num_r  <= NW'({ma, {FRAC_BITS{1'b0}}});
          div_rem_r  <= '0;
          div_quo_r  <= '0;
          div_d_r    <= mb;
        end else begin
          out_valid          <= 1'b1;
          out_result         <= fr;
          out_a_less         <= q_cls.lt;
          out_a_equal        <= q_cls.eq;
          out_a_greater      <= q_cls.gt;
          out_divide_by_zero <= q_cls.is_div;
          out_overflow       <= fovf;
        end
      end
      if (mul_ph_r == 2'd1 || mul_ph_r == 2'd2) begin
        prod_r   <= prod_r + pp;
        mul_ph_r <= mul_ph_r + 2'd1;
      end else if (mul_ph_r == 2'd3) begin
        mul_ph_r           <= 2'd0;
        out_valid          <= 1'b1;
        out_result         <= mres[W-1:0];
        out_overflow       <= mres[W];
        out_divide_by_zero <= 1'b0;
        out_a_less         <= cls_r.lt;
        out_a_equal        <= cls_r.eq;
        out_a_greater      <= cls_r.gt;
      end
      if (div_busy_r) begin
        if (div_cnt_r != '0) begin
          div_num_r <= div_num_r << 1;
          div_cnt_r <= div_cnt_r - 1'b1;
          if (!trial[W]) begin
            div_rem_r <= trial;
            div_quo_r <= {div_quo_r[NW-2:0], 1'b1};
          end else begin
            div_rem_r <= shifted;
            div_quo_r <= {div_quo_r[NW-2:0], 1'b0};
          end
        end else begin
          div_busy_r         <= 1'b0;
          out_valid          <= 1'b1;
          out_result         <= dres[W-1:0];
          out_overflow       <= dres[W];
          out_divide_by_zero <= 1'b0;
          out_a_less         <= cls_r.lt;
          out_a_equal        <= cls_r.eq;
          out_a_greater      <= cls_r.gt;
        end
      end
    end
  end
endmodule

@@ rtl/fixed_point_alu_q24_8.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed saturating fixed-point alu, front decode stage and execute back end.
// ----------------------------------------------------------------------------
// Add, sub, min, max, inc, dec and integer part take one beat per cycle while
// busy is low; the result passes through the front register and the output
// register. Multiply holds the back end while four half-width partial products
// are summed two at a time into the product register; divide holds it while
// the restoring divider makes one quotient bit a cycle. busy is high while the
// front stage is holding an item that the back end cannot take yet. Each
// result shows for one cycle with out_valid; the receiver cannot stall it.
module fixed_point_alu_q24_8 #(
  parameter int FRAC_BITS  = 8,
  parameter int WORD_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [fpa_pkg::OP_WIDTH-1:0] in_opcode,
  input  logic signed [WORD_WIDTH-1:0] in_operand_a,
  input  logic signed [WORD_WIDTH-1:0] in_operand_b,
  output logic                         out_valid,
  output logic signed [WORD_WIDTH-1:0] out_result,
  output logic                         out_a_less,
  output logic                         out_a_equal,
  output logic                         out_a_greater,
  output logic                         out_divide_by_zero,
  output logic                         out_overflow
);
  import fpa_pkg::*;

  logic                         q_valid, q_pop, take;
  cls_t                         q_cls;
  logic signed [WORD_WIDTH-1:0] q_a, q_b;
  logic                         q_valid_raw;
  logic                         held_r;

  // one-entry queue in the front register: refill when empty or draining
  assign busy = q_valid && !q_pop;
  assign take = start && !busy;

  fpa_front #(.WORD_WIDTH(WORD_WIDTH)) u_front (
    .clk, .rst_n,
    .in_take(take), .in_opcode, .in_operand_a, .in_operand_b,
    .q_valid(q_valid_raw), .q_cls, .q_a, .q_b
  );

  // front register stays full while the back end is busy
  always_ff @(posedge clk) begin
    if (!rst_n) held_r <= 1'b0;
    else        held_r <= q_valid && !q_pop && !take;
  end
  assign q_valid = q_valid_raw || held_r;

  fpa_back #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n,
    .q_valid, .q_cls, .q_a, .q_b, .q_pop,
    .out_valid, .out_result, .out_a_less, .out_a_equal, .out_a_greater,
    .out_divide_by_zero, .out_overflow
  );
endmodule
